// ===== rtl/fisp_pkg.sv =====
// ----------------------------------------------------------------------------
// fisp_pkg
// Shared types, codes and constant tables of the flux image stream parser.
// ----------------------------------------------------------------------------
package fisp_pkg;

    typedef enum logic [1:0] {
        PH_FILE = 2'd0,
        PH_THDR = 2'd1,
        PH_DATA = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_TRACK = 2'd0;
    localparam logic [1:0] KIND_FLUX  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_MAGIC     = 3'd3;
    localparam logic [2:0] ERR_CLOCK     = 3'd4;
    localparam logic [2:0] ERR_NO_INDEX  = 3'd5;

    // file and track header layout
    localparam logic [4:0] SIG_LEN       = 5'd15;
    localparam logic [4:0] VERSION_POS   = 5'd16;
    localparam logic [4:0] FILE_HDR_LAST = 5'd31;
    localparam logic [7:0] VERSION_CHAR  = 8'h33;
    localparam logic [7:0] TRACK_MAGIC   = 8'hCA;
    localparam logic [7:0] CLOCK_LIMIT   = 8'd3;

    localparam logic [2:0] TH_MAGIC  = 3'd0;
    localparam logic [2:0] TH_TRACK  = 3'd1;
    localparam logic [2:0] TH_CLOCK  = 3'd2;
    localparam logic [2:0] TH_FLAGS  = 3'd3;
    localparam logic [2:0] TH_SIZE0  = 3'd4;
    localparam logic [2:0] TH_SIZE1  = 3'd5;
    localparam logic [2:0] TH_SIZE2  = 3'd6;
    localparam logic [2:0] TH_SIZE3  = 3'd7;

    // track flag bits
    localparam int FLAG_INDEX_IN_DATA = 1;
    localparam int FLAG_INDEX_ALIGN   = 2;
    localparam int FLAG_NO_CORR       = 3;

    localparam logic [1:0] HEAD_COUNT_RESET = 2'd2;

    // flux conversion: ns = (count * tick_ps) / 1000
    localparam int COUNT_W = 9;
    localparam int TICK_W  = 18;
    localparam int PROD_W  = COUNT_W + TICK_W;
    // divide by 1000 as shift by 3, then multiply by ceil(2^30 / 125)
    localparam int DIV_PRE_SHIFT = 3;
    localparam int QUOT_IN_W     = PROD_W - DIV_PRE_SHIFT;
    localparam int DIV_SHIFT     = 30;
    localparam int DIV_MUL_W     = 24;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd8589935;
    localparam int NS_W = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         cylinder;
        logic               head;
        logic [1:0]         clock_code;
        logic [31:0]        track_length;
        logic [COUNT_W-1:0] flux_count;
        logic               starts_rev;
        logic               last;
        logic [2:0]         error_code;
    } res_t;

    function automatic logic [7:0] sig_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h77; // w
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h6F; // o
            4'd4:    c = 8'h6F; // o
            4'd5:    c = 8'h6C; // l
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h72; // r
            4'd8:    c = 8'h61; // a
            4'd9:    c = 8'h77; // w
            4'd10:   c = 8'h20;
            4'd11:   c = 8'h64; // d
            4'd12:   c = 8'h61; // a
            4'd13:   c = 8'h74; // t
            4'd14:   c = 8'h61; // a
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // sample tick in picoseconds per clock code
    function automatic logic [TICK_W-1:0] tick_ps(input logic [1:0] code);
        logic [TICK_W-1:0] t;
        case (code)
            2'd0:    t = 18'd141232;
            2'd1:    t = 18'd70616;
            default: t = 18'd35308;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/fisp_parser.sv =====
// ----------------------------------------------------------------------------
// fisp_parser
// Header parser: file and track header checks, track state, and the first
// result register holding the raw flux count.
// ----------------------------------------------------------------------------
module fisp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output fisp_pkg::res_t    res
);
    import fisp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  track_reg, track_next;
    logic [1:0]  clock_reg, clock_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] remain_reg, remain_next;
    logic        prev_idx_reg, prev_idx_next;
    logic        nonempty_reg, nonempty_next;
    logic [2:0]  err_reg, err_next;
    logic [1:0]  head_count_reg;
    logic        valid_reg;
    res_t        res_reg, res_next;
    logic        emit;
    logic        fire;

    logic        two_heads;
    logic [7:0]  tnum;
    logic [8:0]  count;
    logic        corr;
    logic        starts;

    assign s_ready   = !valid_reg || res_ready;
    assign fire      = s_valid && s_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign two_heads = head_count_reg[1];

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        track_next    = track_reg;
        clock_next    = clock_reg;
        flags_next    = flags_reg;
        remain_next   = remain_reg;
        prev_idx_next = prev_idx_reg;
        nonempty_next = nonempty_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        res_next      = '0;
        tnum          = track_reg;
        count         = '0;
        corr          = !flags_reg[FLAG_NO_CORR];
        starts        = 1'b0;

        case (phase_reg)
            PH_FILE: begin
                if (pos_reg < SIG_LEN && s_data_byte != sig_char(pos_reg[3:0])) begin
                    err_next = ERR_SIGNATURE;
                end else if (pos_reg == VERSION_POS && s_data_byte != VERSION_CHAR) begin
                    err_next = ERR_VERSION;
                end else if (pos_reg == FILE_HDR_LAST) begin
                    phase_next = PH_THDR;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            PH_THDR: begin
                pos_next = pos_reg + 5'd1;
                case (pos_reg[2:0])
                    TH_MAGIC: begin
                        if (s_data_byte != TRACK_MAGIC) err_next = ERR_MAGIC;
                    end
                    TH_TRACK: track_next = s_data_byte;
                    TH_CLOCK: begin
                        if (s_data_byte >= CLOCK_LIMIT) err_next = ERR_CLOCK;
                        clock_next = s_data_byte[1:0];
                    end
                    TH_FLAGS: begin
                        if (!s_data_byte[FLAG_INDEX_ALIGN]) err_next = ERR_NO_INDEX;
                        flags_next = s_data_byte;
                    end
                    TH_SIZE0: remain_next[7:0]   = s_data_byte;
                    TH_SIZE1: remain_next[15:8]  = s_data_byte;
                    TH_SIZE2: remain_next[23:16] = s_data_byte;
                    TH_SIZE3: begin
                        remain_next[31:24] = s_data_byte;
                        pos_next           = '0;
                        prev_idx_next      = 1'b0;
                        nonempty_next      = 1'b0;
                        emit               = 1'b1;
                        res_next.kind         = KIND_TRACK;
                        res_next.cylinder     = two_heads ? {1'b0, tnum[7:1]} : tnum;
                        res_next.head         = two_heads & tnum[0];
                        res_next.clock_code   = clock_reg;
                        res_next.track_length = remain_next;
                        res_next.last         = (remain_next == '0);
                        phase_next = (remain_next == '0) ? PH_THDR : PH_DATA;
                    end
                    default: ;
                endcase
            end
            PH_DATA: begin
                if (flags_reg[FLAG_INDEX_IN_DATA]) begin
                    count         = {2'b00, s_data_byte[6:0]} + {8'd0, corr};
                    starts        = s_data_byte[7] & !prev_idx_reg & nonempty_reg;
                    prev_idx_next = s_data_byte[7];
                end else begin
                    count = {1'b0, s_data_byte} + {8'd0, corr};
                end
                nonempty_next = 1'b1;
                remain_next   = remain_reg - 32'd1;
                emit          = 1'b1;
                res_next.kind       = KIND_FLUX;
                res_next.cylinder   = two_heads ? {1'b0, tnum[7:1]} : tnum;
                res_next.head       = two_heads & tnum[0];
                res_next.clock_code = clock_reg;
                res_next.flux_count = count;
                res_next.starts_rev = starts;
                if (remain_reg == 32'd1) begin
                    res_next.last = 1'b1;
                    phase_next    = PH_THDR;
                    pos_next      = '0;
                end
            end
            default: ;
        endcase

        // any failed check, or an already kept one, turns the byte into an error
        if (phase_reg == PH_ERR || err_next != err_reg) begin
            phase_next          = PH_ERR;
            emit                = 1'b1;
            res_next            = '0;
            res_next.kind       = KIND_ERROR;
            res_next.error_code = err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FILE;
            pos_reg        <= '0;
            track_reg      <= '0;
            clock_reg      <= '0;
            flags_reg      <= '0;
            remain_reg     <= '0;
            prev_idx_reg   <= 1'b0;
            nonempty_reg   <= 1'b0;
            err_reg        <= ERR_NONE;
            head_count_reg <= HEAD_COUNT_RESET;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                head_count_reg <= cfg_wr_data;
            end
            if (fire) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                track_reg    <= track_next;
                clock_reg    <= clock_next;
                flags_reg    <= flags_next;
                remain_reg   <= remain_next;
                prev_idx_reg <= prev_idx_next;
                nonempty_reg <= nonempty_next;
                err_reg      <= err_next;
            end
            if (s_ready) begin
                valid_reg <= fire && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/fisp_flux_calc.sv =====
// ----------------------------------------------------------------------------
// fisp_flux_calc
// Two-stage flux conversion: count times tick period, then divide by 1000
// through a reciprocal multiply. The second stage is the output register.
// ----------------------------------------------------------------------------
module fisp_flux_calc (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       res_valid,
    output logic                       res_ready,
    input  fisp_pkg::res_t             res,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fisp_pkg::res_t             m_res,
    output logic [fisp_pkg::NS_W-1:0]  m_ns
);
    import fisp_pkg::*;

    localparam int QPROD_W = QUOT_IN_W + DIV_MUL_W;

    logic                 mid_valid_reg;
    res_t                 mid_res_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic [NS_W-1:0]      ns_reg;
    logic [NS_W-1:0]      ns_next;
    logic [QPROD_W-1:0]   qprod;
    logic                 out_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign res_ready = !mid_valid_reg || out_ready;

    assign prod_next = PROD_W'(res.flux_count) * PROD_W'(tick_ps(res.clock_code));
    assign qprod     = QPROD_W'(prod_reg[PROD_W-1:DIV_PRE_SHIFT]) * QPROD_W'(DIV_MUL);
    assign ns_next   = qprod[DIV_SHIFT +: NS_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (res_ready) begin
                mid_valid_reg <= res_valid;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            mid_res_reg <= res;
            prod_reg    <= prod_next;
        end
        if (out_ready && mid_valid_reg) begin
            out_res_reg <= mid_res_reg;
            ns_reg      <= ns_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;
    assign m_ns    = ns_reg;

endmodule

// ===== rtl/flux_image_stream_parser.sv =====
// ----------------------------------------------------------------------------
// flux_image_stream_parser
// Parses a raw flux disk image byte stream into track starts, flux
// intervals in nanoseconds and sticky errors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  s_       | in        | s_valid / s_ready   | s_data_byte
//  m_       | out       | m_valid / m_ready   | kind, track, flux, error fields
//  cfg_     | in        | cfg_wr_en           | cfg_wr_data (head count)
//
// One byte per cycle, back to back, while m_ready does not stall. A request
// that yields a result shows on m_ through three registers (header
// register, tick multiply, divide-by-1000 output register).
// Reset is synchronous and clears the parser to the file header state with
// head count 2. A stall on m_ready fills the stages back to s_ready.
// ----------------------------------------------------------------------------
module flux_image_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_cylinder,
    output logic        m_head,
    output logic [1:0]  m_clock_code,
    output logic [31:0] m_track_length,
    output logic [15:0] m_flux_ns,
    output logic        m_starts_revolution,
    output logic        m_last_in_track,
    output logic [2:0]  m_error_code
);
    import fisp_pkg::*;

    logic            res_valid;
    logic            res_ready;
    res_t            res;
    res_t            out_res;
    logic [NS_W-1:0] out_ns;

    fisp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    fisp_flux_calc u_flux_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (out_res),
        .m_ns      (out_ns)
    );

    assign m_result_kind       = out_res.kind;
    assign m_cylinder          = out_res.cylinder;
    assign m_head              = out_res.head;
    assign m_clock_code        = out_res.clock_code;
    assign m_track_length      = out_res.track_length;
    assign m_flux_ns           = out_ns;
    assign m_starts_revolution = out_res.starts_rev;
    assign m_last_in_track     = out_res.last;
    assign m_error_code        = out_res.error_code;

endmodule
